// File: rtl/frame_playout_pacer_top_defines.svh
// Assertion macros shared by the frame playout pacer RTL
`ifndef FRAME_PLAYOUT_PACER_TOP_DEFINES_SVH
`define FRAME_PLAYOUT_PACER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define FPP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FPP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FPP_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define FPP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/fpp_pkg.sv
// Types and constants of the frame playout pacer
package fpp_pkg;

    localparam int CFG_ADDR_W = 5;

    localparam logic [2:0] REG_BUFFER_TIME    = 3'd0;
    localparam logic [2:0] REG_STREAK_NEEDED  = 3'd1;
    localparam logic [2:0] REG_AVG_GAP_TOL    = 3'd2;
    localparam logic [2:0] REG_SINGLE_GAP_TOL = 3'd3;
    localparam logic [2:0] REG_DRIFT_FACTOR   = 3'd4;
    localparam logic [2:0] REG_WAIT_FACTOR    = 3'd5;
    localparam logic [2:0] REG_TRACK_FACTOR   = 3'd6;

    typedef enum logic [1:0] {
        ACT_SKIP   = 2'd0,
        ACT_RECORD = 2'd1,
        ACT_PACED  = 2'd2
    } t_action;

    typedef struct packed {
        logic [47:0] arrival_us;
        logic [47:0] media_stamp_us;
        logic [47:0] prior_leave_us;
        logic [31:0] feed_gap_us;
        logic [31:0] mean_feed_gap_us;
        logic [31:0] mean_stamp_gap_us;
    } t_in_item;

    typedef struct packed {
        logic [31:0] hold_us;
        t_action     action;
        logic        balanced;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] buffer_time_us;
        logic [7:0]         balance_streak_needed;
        logic [31:0]        average_gap_tolerance;
        logic [31:0]        single_gap_tolerance;
        logic [15:0]        drift_factor_q8;
        logic [15:0]        wait_factor_q8;
        logic [15:0]        track_factor_q8;
    } t_cfg;

endpackage

// File: rtl/fpp_cfg.sv
// APB configuration registers of the frame playout pacer
module fpp_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output fpp_pkg::t_cfg                   o_cfg
);

    fpp_pkg::t_cfg r_cfg;
    fpp_pkg::t_cfg n_cfg;
    logic [2:0]    w_idx;

    assign w_idx  = paddr[fpp_pkg::CFG_ADDR_W-1:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (psel && penable && pwrite) begin
            case (w_idx)
                fpp_pkg::REG_BUFFER_TIME:    n_cfg.buffer_time_us        = pwdata;
                fpp_pkg::REG_STREAK_NEEDED:  n_cfg.balance_streak_needed = pwdata[7:0];
                fpp_pkg::REG_AVG_GAP_TOL:    n_cfg.average_gap_tolerance = pwdata;
                fpp_pkg::REG_SINGLE_GAP_TOL: n_cfg.single_gap_tolerance  = pwdata;
                fpp_pkg::REG_DRIFT_FACTOR:   n_cfg.drift_factor_q8       = pwdata[15:0];
                fpp_pkg::REG_WAIT_FACTOR:    n_cfg.wait_factor_q8        = pwdata[15:0];
                fpp_pkg::REG_TRACK_FACTOR:   n_cfg.track_factor_q8       = pwdata[15:0];
                default:                     n_cfg = r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            fpp_pkg::REG_BUFFER_TIME:    prdata = r_cfg.buffer_time_us;
            fpp_pkg::REG_STREAK_NEEDED:  prdata = {24'd0, r_cfg.balance_streak_needed};
            fpp_pkg::REG_AVG_GAP_TOL:    prdata = r_cfg.average_gap_tolerance;
            fpp_pkg::REG_SINGLE_GAP_TOL: prdata = r_cfg.single_gap_tolerance;
            fpp_pkg::REG_DRIFT_FACTOR:   prdata = {16'd0, r_cfg.drift_factor_q8};
            fpp_pkg::REG_WAIT_FACTOR:    prdata = {16'd0, r_cfg.wait_factor_q8};
            fpp_pkg::REG_TRACK_FACTOR:   prdata = {16'd0, r_cfg.track_factor_q8};
            default:                     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

// File: rtl/fpp_core.sv
// Pacing state and hold time calculation of the frame playout pacer
`include "frame_playout_pacer_top_defines.svh"

module fpp_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  fpp_pkg::t_in_item  i_item,
    input  fpp_pkg::t_cfg      i_cfg,
    output fpp_pkg::t_out_item o_result
);

    logic               r_balanced;
    logic [7:0]         r_streak;
    logic               r_recorded;
    logic               r_base_set;
    logic [47:0]        r_stamp_base;
    logic signed [63:0] r_clock_base;
    logic [47:0]        r_last_arrival;
    logic [47:0]        r_last_stamp;
    logic signed [63:0] r_cur_wait;
    logic signed [63:0] r_drift;

    logic               w_skip;
    logic [32:0]        w_d_avg;
    logic [32:0]        w_d_one;
    logic [31:0]        w_mag_avg;
    logic [31:0]        w_mag_one;
    logic               w_gaps_ok;
    logic [7:0]         w_streak_next;
    logic               w_bal_now;
    logic               w_paced;
    logic signed [63:0] w_arrival;
    logic signed [63:0] w_stamp;
    logic signed [63:0] w_leave;
    logic signed [63:0] w_sbase;
    logic signed [63:0] w_cbase;
    logic signed [63:0] w_interval;
    logic signed [63:0] w_elapse;
    logic signed [63:0] w_render;
    logic signed [63:0] w_drift1;
    logic signed [63:0] w_clock;
    logic signed [63:0] w_wait0;
    logic signed [63:0] w_thr;
    logic signed [63:0] w_wthr;
    logic signed [63:0] w_tthr;
    logic signed [63:0] w_s;
    logic signed [63:0] w_wait1;
    logic signed [63:0] w_drift2;
    logic signed [63:0] w_offset;
    logic signed [63:0] w_wait2;
    logic signed [63:0] w_wait3;

    // trunc(interval * factor / 256), rounded toward zero
    function automatic logic signed [63:0] f_scaled(input logic signed [63:0] iv,
                                                     input logic [15:0] fac);
        logic [63:0] m;
        logic [63:0] p;
        logic [63:0] q;
        m = iv[63] ? 64'(-iv) : 64'(iv);
        p = {16'd0, m[47:0]} * {48'd0, fac};
        q = p >> 8;
        return iv[63] ? -$signed(q) : $signed(q);
    endfunction

    assign w_skip    = (i_item.media_stamp_us == 48'd0);
    assign w_d_avg   = {1'b0, i_item.mean_feed_gap_us} - {1'b0, i_item.mean_stamp_gap_us};
    assign w_d_one   = {1'b0, i_item.feed_gap_us} - {1'b0, i_item.mean_feed_gap_us};
    assign w_mag_avg = w_d_avg[32] ? 32'(-w_d_avg) : w_d_avg[31:0];
    assign w_mag_one = w_d_one[32] ? 32'(-w_d_one) : w_d_one[31:0];
    assign w_gaps_ok = (i_item.mean_feed_gap_us != 32'd0)
                    && (i_item.mean_stamp_gap_us != 32'd0)
                    && (w_mag_avg < i_cfg.average_gap_tolerance)
                    && (w_mag_one < i_cfg.single_gap_tolerance);

    always_comb begin
        if (!w_gaps_ok) begin
            w_streak_next = 8'd0;
        end else if (r_streak == 8'hFF) begin
            w_streak_next = r_streak;
        end else begin
            w_streak_next = r_streak + 8'd1;
        end
    end

    assign w_bal_now = r_balanced || (w_streak_next >= i_cfg.balance_streak_needed);
    assign w_paced   = !w_skip && w_bal_now && r_recorded;

    assign w_arrival = {16'd0, i_item.arrival_us};
    assign w_stamp   = {16'd0, i_item.media_stamp_us};
    assign w_leave   = {16'd0, i_item.prior_leave_us};
    assign w_sbase   = r_base_set ? {16'd0, r_stamp_base} : w_stamp;
    assign w_cbase   = r_base_set ? r_clock_base
                                  : w_arrival + 64'(i_cfg.buffer_time_us);

    assign w_interval = w_stamp - {16'd0, r_last_stamp};
    assign w_elapse   = w_arrival - w_leave;
    assign w_render   = w_arrival - {16'd0, r_last_arrival};
    assign w_drift1   = r_drift + ((w_render - r_cur_wait) - w_elapse);
    assign w_clock    = (w_sbase + w_arrival) - w_cbase;
    assign w_wait0    = w_interval - w_elapse;

    assign w_thr  = f_scaled(w_interval, i_cfg.drift_factor_q8);
    assign w_wthr = f_scaled(w_interval, i_cfg.wait_factor_q8);
    assign w_tthr = f_scaled(w_interval, i_cfg.track_factor_q8);

    assign w_s = w_wait0 - w_thr;

    always_comb begin
        if ((w_drift1 > w_thr) && (w_wait0 > 64'sd0)) begin
            w_wait1  = w_s;
            w_drift2 = w_drift1 - (w_s < 64'sd0 ? w_wait0 : w_thr);
        end else if (w_drift1 < -w_thr) begin
            w_wait1  = w_wait0 + w_drift1;
            w_drift2 = 64'sd0;
        end else begin
            w_wait1  = w_wait0;
            w_drift2 = w_drift1;
        end
    end

    assign w_offset = (w_stamp - w_wait1) - w_clock;
    assign w_wait2  = ((w_offset > w_wthr) || (w_offset < -w_tthr)) ? w_wait1 + w_offset
                                                                     : w_wait1;
    assign w_wait3  = (w_wait2 < 64'sd0) ? 64'sd0 : w_wait2;

    always_comb begin
        o_result.hold_us  = 32'd0;
        o_result.balanced = r_balanced;
        o_result.action   = fpp_pkg::ACT_SKIP;
        if (!w_skip) begin
            o_result.balanced = w_bal_now;
            if (w_paced) begin
                o_result.action  = fpp_pkg::ACT_PACED;
                o_result.hold_us = (w_wait3[63:32] != 32'd0) ? 32'hFFFF_FFFF : w_wait3[31:0];
            end else begin
                o_result.action = fpp_pkg::ACT_RECORD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_balanced     <= 1'b0;
            r_streak       <= 8'd0;
            r_recorded     <= 1'b0;
            r_base_set     <= 1'b0;
            r_stamp_base   <= 48'd0;
            r_clock_base   <= 64'sd0;
            r_last_arrival <= 48'd0;
            r_last_stamp   <= 48'd0;
            r_cur_wait     <= 64'sd0;
            r_drift        <= 64'sd0;
        end else if (i_step && !w_skip) begin
            if (!r_balanced) begin
                r_streak   <= w_streak_next;
                r_balanced <= w_bal_now;
            end
            r_last_arrival <= i_item.arrival_us;
            r_last_stamp   <= i_item.media_stamp_us;
            r_recorded     <= 1'b1;
            if (w_paced) begin
                r_base_set   <= 1'b1;
                r_stamp_base <= w_sbase[47:0];
                r_clock_base <= w_cbase;
                r_cur_wait   <= w_wait3;
                r_drift      <= w_drift2;
            end
        end
    end

    `FPP_ASSERT_NEXT(a_balanced_sticks, i_clk, i_rst_n, r_balanced, r_balanced)
    `FPP_ASSERT_NOW(a_base_needs_balance, i_clk, i_rst_n, r_base_set, r_balanced && r_recorded)
    `FPP_ASSERT_NEXT(a_paced_sets_base, i_clk, i_rst_n, i_step && w_paced, r_base_set)

endmodule

// File: rtl/frame_playout_pacer_top.sv
// A result passes through the input register and then the result register.
// Throughput: one frame per cycle unless stalled; each frame is done in one pass of the
// core logic, and the pacing state is updated in the same cycle the result register is loaded.
// Input stall rises only when both registers are full and the result transfer is stalled.
// Reset (i_rst_n low at a clock edge) clears both valid flags, the pacing state and the config.
// Top level of the frame playout pacer
`include "frame_playout_pacer_top_defines.svh"

module frame_playout_pacer_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  fpp_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output fpp_pkg::t_out_item             o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [fpp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    fpp_pkg::t_cfg      w_cfg;
    fpp_pkg::t_in_item  r_in;
    logic               r_in_vld;
    logic               n_in_vld;
    fpp_pkg::t_out_item r_out;
    logic               r_out_vld;
    logic               n_out_vld;
    fpp_pkg::t_out_item w_result;
    logic               w_adv;
    logic               w_accept;

    fpp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    fpp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_adv),
        .i_item   (r_in),
        .i_cfg    (w_cfg),
        .o_result (w_result)
    );

    assign w_adv      = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_adv;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign n_in_vld   = w_accept || (r_in_vld && !w_adv);
    assign n_out_vld  = w_adv || (r_out_vld && i_out_stall);

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_data;
        end
        if (w_adv) begin
            r_out <= w_result;
        end
    end

    `FPP_ASSERT_NEXT(a_out_drains, i_clk, i_rst_n, r_out_vld && !i_out_stall && !w_adv, !r_out_vld)
    `FPP_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_accept && r_in_vld, w_adv)
    `FPP_ASSERT_NEXT(a_adv_fills_out, i_clk, i_rst_n, w_adv, r_out_vld)

endmodule

// File: tb/sv/hold_time_checker.sv
// Hold-time predictor and result checker for the frame playout pacer
module hold_time_checker
    import fpp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  t_out_item             i_out_data,
    input  logic                  i_psel,
    input  logic                  i_penable,
    input  logic                  i_pwrite,
    input  logic                  i_pready,
    input  logic [CFG_ADDR_W-1:0] i_paddr,
    input  logic [31:0]           i_pwdata,
    output int                    o_fail_count,
    output int                    o_open_count
);

    t_cfg               cfg;
    logic               bal_flag;
    logic [7:0]         streak_cnt;
    logic               have_times;
    logic               base_set;
    logic [47:0]        stamp_base;
    logic [47:0]        prev_arrival;
    logic [47:0]        prev_stamp;
    logic signed [63:0] clock_base;
    logic signed [63:0] last_hold;
    logic signed [63:0] drift_acc;

    t_out_item          due_holds[$];
    t_out_item          want;
    t_out_item          fresh;
    int                 n_results = 0;

    initial o_fail_count = 0;
    initial o_open_count = 0;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [63:0] scale_q8(input logic signed [63:0] itv,
                                                    input logic [15:0] fac);
        logic [63:0] m;
        logic [63:0] q;
        m = mag64(itv);
        if (m > 64'h0000_FFFF_FFFF_FFFF) begin
            m = 64'h0000_FFFF_FFFF_FFFF;
        end
        q = (m * {48'd0, fac}) >> 8;
        return (itv < 0) ? -$signed(q) : $signed(q);
    endfunction

    task automatic pace_frame(input t_in_item f, output t_out_item r);
        logic signed [63:0] arr, stp, lv, itv, elp, rnd, clk_off;
        logic signed [63:0] hold, thr, cut, ofs, wthr, tthr;
        logic signed [63:0] d_avg, d_one;
        logic               gaps_ok;
        arr = {16'd0, f.arrival_us};
        stp = {16'd0, f.media_stamp_us};
        lv  = {16'd0, f.prior_leave_us};
        r.hold_us  = '0;
        r.action   = ACT_SKIP;
        r.balanced = bal_flag;
        if (f.media_stamp_us != '0) begin
            if (!bal_flag) begin
                d_avg = {32'd0, f.mean_feed_gap_us} - {32'd0, f.mean_stamp_gap_us};
                d_one = {32'd0, f.feed_gap_us} - {32'd0, f.mean_feed_gap_us};
                gaps_ok = (f.mean_feed_gap_us != '0) && (f.mean_stamp_gap_us != '0) &&
                          (mag64(d_avg) < {32'd0, cfg.average_gap_tolerance}) &&
                          (mag64(d_one) < {32'd0, cfg.single_gap_tolerance});
                if (gaps_ok) begin
                    if (streak_cnt != 8'hFF) begin
                        streak_cnt = streak_cnt + 8'd1;
                    end
                end else begin
                    streak_cnt = '0;
                end
                if (streak_cnt >= cfg.balance_streak_needed) begin
                    bal_flag = 1'b1;
                end
            end
            if (!bal_flag || !have_times) begin
                r.action   = ACT_RECORD;
                r.balanced = bal_flag;
            end else begin
                if (!base_set) begin
                    stamp_base = f.media_stamp_us;
                    clock_base = arr + {{32{cfg.buffer_time_us[31]}}, cfg.buffer_time_us};
                    base_set   = 1'b1;
                end
                itv = stp - {16'd0, prev_stamp};
                elp = arr - lv;
                rnd = arr - {16'd0, prev_arrival};
                drift_acc = drift_acc + (rnd - last_hold - elp);
                clk_off = {16'd0, stamp_base} + arr - clock_base;
                hold = itv - elp;
                thr = scale_q8(itv, cfg.drift_factor_q8);
                if (drift_acc > thr && hold > 0) begin
                    cut = hold - thr;
                    drift_acc = drift_acc - ((cut < 0) ? hold : thr);
                    hold = cut;
                end else if (drift_acc < -thr) begin
                    hold = hold + drift_acc;
                    drift_acc = '0;
                end
                wthr = scale_q8(itv, cfg.wait_factor_q8);
                tthr = scale_q8(itv, cfg.track_factor_q8);
                ofs = stp - hold - clk_off;
                if (ofs > wthr || ofs < -tthr) begin
                    hold = hold + ofs;
                end
                if (hold < 0) begin
                    hold = '0;
                end
                last_hold  = hold;
                r.hold_us  = (hold > 64'sh0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : hold[31:0];
                r.action   = ACT_PACED;
                r.balanced = 1'b1;
            end
            prev_arrival = f.arrival_us;
            prev_stamp   = f.media_stamp_us;
            have_times   = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg          = '0;
            bal_flag     = 1'b0;
            streak_cnt   = '0;
            have_times   = 1'b0;
            base_set     = 1'b0;
            stamp_base   = '0;
            prev_arrival = '0;
            prev_stamp   = '0;
            clock_base   = '0;
            last_hold    = '0;
            drift_acc    = '0;
            due_holds.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[CFG_ADDR_W-1:2])
                    REG_BUFFER_TIME:    cfg.buffer_time_us        = i_pwdata;
                    REG_STREAK_NEEDED:  cfg.balance_streak_needed = i_pwdata[7:0];
                    REG_AVG_GAP_TOL:    cfg.average_gap_tolerance = i_pwdata;
                    REG_SINGLE_GAP_TOL: cfg.single_gap_tolerance  = i_pwdata;
                    REG_DRIFT_FACTOR:   cfg.drift_factor_q8       = i_pwdata[15:0];
                    REG_WAIT_FACTOR:    cfg.wait_factor_q8        = i_pwdata[15:0];
                    REG_TRACK_FACTOR:   cfg.track_factor_q8       = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                n_results++;
                if (due_holds.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("result %0d unexpected: hold %0d action %0d balanced %0d",
                                 n_results, i_out_data.hold_us, i_out_data.action,
                                 i_out_data.balanced);
                    end
                    o_fail_count++;
                end else begin
                    want = due_holds.pop_front();
                    if (i_out_data.hold_us !== want.hold_us ||
                        i_out_data.action !== want.action ||
                        i_out_data.balanced !== want.balanced) begin
                        if (o_fail_count < 10) begin
                            $display("result %0d mismatch: hold exp %0d got %0d, ",
                                     n_results, want.hold_us, i_out_data.hold_us,
                                     "action exp %0d got %0d, balanced exp %0d got %0d",
                                     want.action, i_out_data.action,
                                     want.balanced, i_out_data.balanced);
                        end
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                pace_frame(i_in_data, fresh);
                due_holds.push_back(fresh);
            end
        end
        o_open_count = due_holds.size();
    end

endmodule

// File: tb/sv/tb.sv
// Testbench top for the frame playout pacer: stimulus, configuration and verdict
module tb;
    import fpp_pkg::*;

    localparam int HOLD_OFF_AT     = 300;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_FRAMES    = 160;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_item             o_out_data;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr       = '0;
    logic [31:0]           pwdata      = '0;
    logic [31:0]           prdata;
    logic                  pready;

    int                    n_fail;
    int                    n_open;
    int                    n_offered   = 0;
    logic [47:0]           stream_clk;
    logic [47:0]           stream_stamp;

    always #5 i_clk = ~i_clk;

    frame_playout_pacer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    hold_time_checker hold_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (n_fail),
        .o_open_count (n_open)
    );

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_cfg(input logic [31:0] buf_us, input logic [7:0] streak,
                            input logic [31:0] avg_tol, input logic [31:0] one_tol,
                            input logic [15:0] drift_q8, input logic [15:0] wait_q8,
                            input logic [15:0] track_q8);
        cfg_write(REG_BUFFER_TIME, buf_us);
        cfg_write(REG_STREAK_NEEDED, {24'd0, streak});
        cfg_write(REG_AVG_GAP_TOL, avg_tol);
        cfg_write(REG_SINGLE_GAP_TOL, one_tol);
        cfg_write(REG_DRIFT_FACTOR, {16'd0, drift_q8});
        cfg_write(REG_WAIT_FACTOR, {16'd0, wait_q8});
        cfg_write(REG_TRACK_FACTOR, {16'd0, track_q8});
    endtask

    task automatic send_frame(input t_in_item f);
        int gap;
        gap = (((n_offered / 40) % 5) == 2) ? 0 : $urandom_range(0, 15);
        n_offered++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= f;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic send_fields(input logic [47:0] arr, input logic [47:0] stamp,
                               input logic [47:0] leave, input logic [31:0] feed,
                               input logic [31:0] mean_feed, input logic [31:0] mean_stamp);
        t_in_item f;
        f.arrival_us        = arr;
        f.media_stamp_us    = stamp;
        f.prior_leave_us    = leave;
        f.feed_gap_us       = feed;
        f.mean_feed_gap_us  = mean_feed;
        f.mean_stamp_gap_us = mean_stamp;
        send_frame(f);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (n_open != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic make_frame(output t_in_item f);
        int pick, step, jit, proc, dev;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            f.arrival_us        = rand48();
            f.media_stamp_us    = rand48();
            f.prior_leave_us    = rand48();
            f.feed_gap_us       = $urandom;
            f.mean_feed_gap_us  = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
            f.mean_stamp_gap_us = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        end else begin
            step = $urandom_range(1000, 40000);
            jit  = int'($urandom_range(0, step / 2)) - step / 4;
            dev  = int'($urandom_range(0, 300)) - 150;
            f.mean_stamp_gap_us = 32'(step);
            f.mean_feed_gap_us  = 32'(step + dev);
            f.feed_gap_us       = 32'(step + dev + int'($urandom_range(0, 300)) - 150);
            if ($urandom_range(0, 19) == 0) begin
                step = step * int'($urandom_range(2, 6));
            end
            stream_clk += 48'(step + jit);
            if ($urandom_range(0, 49) == 0) begin
                stream_stamp -= 48'($urandom_range(0, 100000));
            end else begin
                stream_stamp += 48'(step);
            end
            proc = $urandom_range(0, step);
            f.arrival_us     = stream_clk;
            f.media_stamp_us = (pick < 12) ? 48'd0 : stream_stamp;
            f.prior_leave_us = ($urandom_range(0, 15) == 0) ?
                               stream_clk + 48'($urandom_range(0, 500)) :
                               stream_clk - 48'(proc);
        end
    endtask

    initial begin
        #3_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : result_sink
        int n_taken;
        int gap;
        n_taken = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                n_taken++;
                gap = (((n_taken / 50) % 4) == 3) ? 0 : $urandom_range(0, 15);
                if (n_taken == HOLD_OFF_AT) begin
                    gap = HOLD_OFF_CYCLES;
                end
                if (gap > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    initial begin : stimulus
        t_in_item f;
        int       k;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        stream_clk   = rand48() >> 8;
        stream_stamp = rand48() >> 8;

        // unbalanced feed: skip, means unknown, tolerance edges, streak build and reset
        load_cfg(32'd1000, 8'd4, 32'd50, 32'd50, 16'h0040, 16'h0200, 16'h0100);
        send_fields('1, 48'd0, '1, '1, '1, '1);
        send_fields(48'd1000000, 48'd90000, 48'd990000, 32'd33333, 32'd0, 32'd33333);
        send_fields(48'd1033333, 48'd123333, 48'd1025000, 32'd33333, 32'd33333, 32'd0);
        send_fields(48'd1066666, 48'd156666, 48'd1060000, 32'd33383, 32'd33383, 32'd33333);
        send_fields(48'd1100000, 48'd190000, 48'd1090000, 32'd33283, 32'd33333, 32'd33333);
        send_fields(48'd1133333, 48'd223333, 48'd1120000, 32'd33333, 32'd33382, 32'd33333);
        send_fields(48'd1166666, 48'd256666, 48'd1160000, 32'd33333, 32'd33284, 32'd33333);
        send_fields(48'd1200000, 48'd290000, 48'd1195000, 32'd33333, 32'd33333, 32'd33333);
        send_fields(48'd1233333, 48'd323333, 48'd1230000, '1, 32'd33333, 32'd33333);
        send_fields(48'd1266666, 48'd0, 48'd1260000, 32'd33333, 32'd33333, 32'd33333);
        send_fields(48'd1300000, 48'd356666, 48'd1290000, 32'd33333, 32'd33333, 32'd33333);
        send_fields(48'd1333333, 48'd390000, 48'd1330000, 32'd33340, 32'd33333, 32'd33333);
        send_fields(48'd1366666, 48'd423333, 48'd1360000, 32'd33333, 32'd33340, 32'd33333);
        wait_idle();

        // zero threshold: the next stamped frame balances the feed whatever its gaps
        cfg_write(REG_STREAK_NEEDED, 32'd0);
        send_fields(48'd1400000, 48'd456666, 48'd1395000, 32'd0, 32'd0, 32'd0);
        send_fields(48'd1433333, 48'd490000, 48'd1420000, 32'd33333, 32'd33333, 32'd33333);
        send_fields(48'd1466666, '1, 48'd1460000, 32'd33333, 32'd33333, 32'd33333);
        send_fields(48'd1500000, 48'd523333, 48'd1490000, 32'd33333, 32'd33333, 32'd33333);
        send_fields(48'd1533333, 48'd556666, '1, 32'd33333, 32'd33333, 32'd33333);
        send_fields('1, 48'd590000, 48'd0, 32'd33333, 32'd33333, 32'd33333);
        send_fields(48'd1600000, 48'd0, 48'd1590000, 32'd33333, 32'd33333, 32'd33333);
        send_fields(48'd0, 48'd1, 48'd0, 32'd0, 32'd0, 32'd0);
        send_fields(48'd1666666, 48'd656666, 48'd1650000, 32'd33333, 32'd33333, 32'd33333);
        send_fields(48'd1700000, 48'd690000, 48'd1699000, 32'd33333, 32'd33333, 32'd33333);
        wait_idle();

        for (k = 0; k < 5; k++) begin
            case (k)
                0: load_cfg(32'd5000, 8'd255, 32'd0, 32'd0, 16'h0080, 16'h0100, 16'h0100);
                1: load_cfg(32'h8000_0000, 8'd0, '1, '1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: load_cfg(32'h7FFF_FFFF, 8'd1, 32'd0, 32'd0, 16'h0000, 16'h0000, 16'h0000);
                3: load_cfg($urandom_range(0, 200000) - 100000, $urandom_range(0, 255),
                            $urandom, $urandom, $urandom_range(0, 1024),
                            $urandom_range(0, 1024), $urandom_range(0, 1024));
                default: load_cfg($urandom, $urandom_range(0, 255), $urandom, $urandom,
                                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                                  $urandom_range(0, 65535));
            endcase
            repeat (PHASE_FRAMES) begin
                make_frame(f);
                send_frame(f);
            end
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (n_fail == 0 && n_open == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
